// ===== hw/rtl/htsff_pkg.sv =====
// ----------------------------------------------------------------------------
// htsff_pkg
// Shared types and constants for the head/tail/sum frame finder.
// ----------------------------------------------------------------------------
package htsff_pkg;

  localparam int MAX_FRAME_DEF = 16;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [7:0] HEAD_RST = 8'h00;
  localparam logic [7:0] TAIL_RST = 8'h00;
  localparam logic [4:0] LEN_RST  = 5'd8;

  // register index, byte address = 4 * index
  typedef enum logic [1:0] {
    REG_HEAD = 2'd0,
    REG_TAIL = 2'd1,
    REG_LEN  = 2'd2
  } cfg_reg_t;

endpackage

// ===== hw/rtl/head_tail_sum_frame_finder.sv =====
// ----------------------------------------------------------------------------
// head_tail_sum_frame_finder
// Fixed-length frame sync on a byte stream with an additive checksum.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. Each byte is written to a circular byte memory
// together with the running 8-bit prefix sum; a second read port looks up the
// would-be head byte and its prefix, so the checksum test is one subtract and
// compare. On a match the frame is read back from the memory one byte per
// cycle (head first, tlast on the tail) through a two-entry output queue, and
// the window restarts empty. Input throughput is one byte per cycle, except:
// the cycle after a configuration write is not accepted, and while a frame is
// still being read out a byte that would complete the next frame waits until
// the readout is done. Output runs at one byte per cycle while out_tready
// holds. No clearing pass after reset.
// ----------------------------------------------------------------------------
module head_tail_sum_frame_finder
  import htsff_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] rx_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,    // [7:0] frame_byte
  output logic              out_tlast,    // frame_last
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int LW    = $clog2(MAX_FRAME + 1);
  localparam int AW    = $clog2(2 * MAX_FRAME);
  localparam int DEPTH = 1 << AW;

  // ---------------- configuration ----------------
  logic [7:0] head_r, tail_r;
  logic [4:0] flen_r;
  logic       cfg_wr;
  logic       cfg_hold_r;
  cfg_reg_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= HEAD_RST;
      tail_r     <= TAIL_RST;
      flen_r     <= LEN_RST;
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_HEAD: head_r <= cfg_pwdata[7:0];
          REG_TAIL: tail_r <= cfg_pwdata[7:0];
          REG_LEN:  flen_r <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HEAD: cfg_prdata = {{(CFG_DW-8){1'b0}}, head_r};
      REG_TAIL: cfg_prdata = {{(CFG_DW-8){1'b0}}, tail_r};
      REG_LEN:  cfg_prdata = {{(CFG_DW-5){1'b0}}, flen_r};
      default:  cfg_prdata = '0;
    endcase
  end

  logic [LW-1:0] len_act, lm1;

  always_comb begin
    if (flen_r < 5'd3) begin
      len_act = LW'(3);
    end else if (int'(flen_r) > MAX_FRAME) begin
      len_act = LW'(MAX_FRAME);
    end else begin
      len_act = LW'(flen_r);
    end
  end
  assign lm1 = len_act - LW'(1);

  // ---------------- window memory: {prefix, byte} ----------------
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_a_r, rd_b_r;
  logic [AW-1:0] wptr_r, wptr_nxt, raddr_a;
  logic [AW-1:0] ep_r, ep_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [7:0]    b1_r, p1_r, p2_r, p_new, chk_sum;
  logic          in_acc, match, issue;

  assign in_tready = !cfg_hold_r && ((rem_r == '0) || (cnt_r < lm1));
  assign in_acc    = in_tvalid & in_tready;
  assign p_new     = p1_r + in_tdata;
  // sum of bytes strictly between head and checksum
  assign chk_sum   = p2_r - rd_a_r[15:8];
  assign match     = in_acc && (cnt_r >= lm1) && (in_tdata == tail_r)
                     && (rd_a_r[7:0] == head_r) && (chk_sum == b1_r);

  assign wptr_nxt = in_acc ? wptr_r + AW'(1) : wptr_r;
  // head position for the next byte, looked up ahead through the registered read
  assign raddr_a  = wptr_nxt - AW'(lm1);

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    ep_nxt  = ep_r;
    if (in_acc && cnt_r != LW'(MAX_FRAME)) begin
      cnt_nxt = cnt_r + LW'(1);
    end
    if (issue) begin
      rem_nxt = rem_r - LW'(1);
      ep_nxt  = ep_r + AW'(1);
    end
    if (match) begin
      cnt_nxt = '0;
      rem_nxt = len_act;
      ep_nxt  = wptr_r - AW'(lm1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[wptr_r] <= {p_new, in_tdata};
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[ep_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      cnt_r  <= '0;
      rem_r  <= '0;
      ep_r   <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      ep_r   <= ep_nxt;
    end
  end

  // running prefix must start from a known value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (in_acc) begin
      b1_r <= in_tdata;
      p1_r <= p_new;
      p2_r <= p1_r;
    end
  end

  // ---------------- readout queue ----------------
  logic [8:0] fq_r [2];
  logic       fq_wp_r, fq_rp_r;
  logic [1:0] fq_cnt_r, occ;
  logic       pend_r, pend_last_r, pop;

  assign out_tvalid = (fq_cnt_r != 2'd0);
  assign out_tdata  = fq_r[fq_rp_r][7:0];
  assign out_tlast  = fq_r[fq_rp_r][8];
  assign pop        = out_tvalid & out_tready;
  assign occ        = fq_cnt_r + {1'b0, pend_r};
  assign issue      = (rem_r != '0) && ((occ < 2'd2) || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      fq_wp_r  <= 1'b0;
      fq_rp_r  <= 1'b0;
      fq_cnt_r <= 2'd0;
    end else begin
      pend_r <= issue;
      if (pend_r) begin
        fq_wp_r <= ~fq_wp_r;
      end
      if (pop) begin
        fq_rp_r <= ~fq_rp_r;
      end
      fq_cnt_r <= fq_cnt_r + {1'b0, pend_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    pend_last_r <= (rem_r == LW'(1));
    if (pend_r) begin
      fq_r[fq_wp_r] <= {pend_last_r, rd_b_r[7:0]};
    end
  end

  // ---------------- checks ----------------
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= 2'd2)
    else $error("readout queue overrun");

  a_no_match_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    match |-> (rem_r == '0))
    else $error("frame matched while previous frame still read out");

  a_match_loads: assert property (@(posedge clk) disable iff (!rst_n)
    match |=> (rem_r == $past(len_act)) && (cnt_r == '0))
    else $error("readout not started after match");

  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> pend_r)
    else $error("memory read not tracked");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_FRAME)
    else $error("fill count out of range");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the head/tail/sum frame finder.
// ----------------------------------------------------------------------------
// Bytes go in over the input stream. Every accepted byte also goes into a
// local copy of the byte window, which computes the frame bytes the block must
// emit. Received frame bytes are checked against that list in order. The
// register settings change between phases, only once the block has gone
// quiet. Phases draw from valid frames with random payload, frames with one
// byte corrupted, and runs of random noise. Both sides idle at random. In one
// phase the receiver stops for a long time while the sender keeps sending.
// ----------------------------------------------------------------------------
module testbench;
  import htsff_pkg::*;

  localparam int          MAX_FRAME    = MAX_FRAME_DEF;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam int          ITEMS_TARGET = 370;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE       = 8;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  head_tail_sum_frame_finder #(.MAX_FRAME(MAX_FRAME)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow registers
  logic [7:0] cfg_head = HEAD_RST;
  logic [7:0] cfg_tail = TAIL_RST;
  logic [4:0] cfg_len  = LEN_RST;

  // local byte window, oldest byte at index 0
  logic [7:0]  window_bytes [MAX_FRAME];
  int          held_count = 0;
  frame_beat_t expected_beats [$];

  logic [7:0] pending_bytes [$];
  int         n_queued = 0;
  int         n_accepted = 0;
  int         in_idle_max = 0;
  int         out_idle_max = 0;
  bit         hold_armed = 1'b0;
  int         mismatches = 0;
  int         cycle_count = 0;

  function automatic int eff_len(input logic [4:0] l);
    if (l < 3) return 3;
    if (l > MAX_FRAME) return MAX_FRAME;
    return l;
  endfunction

  function void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    int          len;
    int          first;
    int          lastp;
    logic [7:0]  sum;
    frame_beat_t beat;
    len = eff_len(cfg_len);
    if (held_count >= MAX_FRAME) begin
      for (int k = 0; k < MAX_FRAME - 1; k++) window_bytes[k] = window_bytes[k + 1];
      window_bytes[MAX_FRAME - 1] = b;
    end else begin
      window_bytes[held_count] = b;
      held_count++;
    end
    if (held_count < len) return;
    first = held_count - len;
    lastp = held_count - 1;
    if (window_bytes[first] != cfg_head || window_bytes[lastp] != cfg_tail) return;
    sum = '0;
    for (int k = first + 1; k < lastp - 1; k++) sum += window_bytes[k];
    if (sum != window_bytes[lastp - 1]) return;
    for (int k = 0; k < len; k++) begin
      beat.data = window_bytes[first + k];
      beat.last = (k == len - 1);
      expected_beats.push_back(beat);
    end
    for (int k = 0; k < MAX_FRAME; k++) window_bytes[k] = '0;
    held_count = 0;
  endtask

  // input driver: gap drawn per byte, taken after its request completes
  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap    <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bytes.pop_front();
          tx_gap    <= $urandom_range(0, in_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready generator
  int          rx_wait = 0;
  int          rx_draw;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  frame_beat_t got_beat;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      rx_draw = rx_wait;
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          note_mismatch($sformatf("unexpected frame byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          got_beat = expected_beats.pop_front();
          if (out_tdata !== got_beat.data || out_tlast !== got_beat.last)
            note_mismatch($sformatf("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                                    got_beat.data, got_beat.last, out_tdata, out_tlast));
        end
        rx_draw = $urandom_range(0, out_idle_max);
      end
      if (hold_armed && !hold_done && out_tvalid) begin
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_draw != 0) begin
        rx_wait    <= rx_draw - 1;
        out_tready <= 1'b0;
      end else begin
        rx_wait    <= 0;
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // write, then read back over a second request
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    bit          check_rd;
    want     = '0;
    check_rd = 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_HEAD: begin
        cfg_head = val[7:0];
        want     = {24'h0, cfg_head};
      end
      REG_TAIL: begin
        cfg_tail = val[7:0];
        want     = {24'h0, cfg_tail};
      end
      REG_LEN: begin
        cfg_len = val[4:0];
        want    = {27'h0, cfg_len};
      end
      default: check_rd = 1'b0;
    endcase
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (check_rd && cfg_prdata !== want)
      note_mismatch($sformatf("register %0d read: expected %08h, got %08h",
                              idx, want, cfg_prdata));
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    n_queued++;
  endtask

  task automatic queue_frame(input bit corrupt);
    int         len;
    int         pos;
    logic [7:0] frame_buf [MAX_FRAME];
    logic [7:0] sum;
    len = eff_len(cfg_len);
    sum = '0;
    frame_buf[0] = cfg_head;
    for (int k = 1; k < len - 2; k++) begin
      frame_buf[k] = 8'($urandom);
      sum += frame_buf[k];
    end
    frame_buf[len - 2] = sum;
    frame_buf[len - 1] = cfg_tail;
    if (corrupt) begin
      pos = $urandom_range(0, len - 1);
      frame_buf[pos] ^= 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < len; k++) queue_byte(frame_buf[k]);
  endtask

  // every byte accepted, every frame byte seen, then a quiet settle wait
  task automatic wait_drained(input int settle);
    while (n_accepted != n_queued || expected_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [31:0] rnd;
    logic [4:0]  len_pick;
    int          phase;
    int          pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: eight zero bytes form a frame
    repeat (8) queue_byte(8'h00);
    wait_drained(SETTLE);

    // shortest frame, length below three clamps to three
    reg_write(REG_HEAD, 32'h0000_00FF);
    reg_write(REG_TAIL, 32'hFFFF_FF00);
    reg_write(REG_LEN, 32'h0000_0001);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h00);
    wait_drained(SETTLE);

    // longest frame, length above the maximum clamps; checksum wraps
    reg_write(REG_HEAD, 32'h0000_0000);
    reg_write(REG_TAIL, 32'h0000_00FF);
    reg_write(REG_LEN, 32'h0000_001F);
    queue_byte(8'h00);
    repeat (13) queue_byte(8'hFF);
    queue_byte(8'hF3);
    queue_byte(8'hFF);
    wait_drained(SETTLE);

    phase = 0;
    while (n_queued < ITEMS_TARGET) begin
      if (phase == 0 || $urandom_range(0, 2) != 0) reg_write(REG_HEAD, $urandom);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        rnd = $urandom;
        if ($urandom_range(0, 3) == 0) rnd[7:0] = cfg_head;
        reg_write(REG_TAIL, rnd);
      end
      if (phase == 0 || phase == 3 || $urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        if (phase == 3) len_pick = 5'd3;
        else if (pick == 0) len_pick = 5'($urandom_range(0, 2));
        else if (pick == 1) len_pick = 5'($urandom_range(17, 31));
        else if (pick == 2) len_pick = 5'(MAX_FRAME);
        else len_pick = 5'($urandom_range(3, 10));
        rnd = $urandom;
        reg_write(REG_LEN, {rnd[31:5], len_pick});
      end
      if ($urandom_range(0, 7) == 0) reg_write(REG_UNUSED, $urandom);
      in_idle_max  = $urandom_range(0, 1) ? 9 : 0;
      out_idle_max = $urandom_range(0, 1) ? 9 : 0;

      if (phase == 3) begin
        // receiver stalls on the first frame byte; the sender keeps going
        in_idle_max = 0;
        hold_armed  = 1'b1;
        repeat (20) queue_frame(1'b0);
      end else begin
        repeat ($urandom_range(3, 8)) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) queue_frame(1'b0);
          else if (pick == 7) queue_frame(1'b1);
          else repeat ($urandom_range(1, 20)) queue_byte(8'($urandom));
        end
      end
      wait_drained(SETTLE);
      phase++;
    end

    wait_drained(20);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
